### sv/psp_pkg.sv
// shared types and constants for the pcm sample player
`default_nettype none
package psp_pkg;
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_LOAD  = 2'd3
   } cmd_type;

   localparam logic [1:0] CSR_STEP_UNIT  = 2'd0;
   localparam logic [1:0] CSR_ROM_LENGTH = 2'd1;
   localparam logic [1:0] CSR_BANK_SHIFT = 2'd2;
   localparam logic [1:0] CSR_BANK_MASK  = 2'd3;

   localparam logic [10:0] OFS_LVOL  = 11'h002;
   localparam logic [10:0] OFS_RVOL  = 11'h003;
   localparam logic [10:0] OFS_ADRL  = 11'h004;
   localparam logic [10:0] OFS_ADRH  = 11'h005;
   localparam logic [10:0] OFS_ENDP  = 11'h006;
   localparam logic [10:0] OFS_DELTA = 11'h007;
   localparam logic [10:0] OFS_LOOPL = 11'h084;
   localparam logic [10:0] OFS_LOOPH = 11'h085;
   localparam logic [10:0] OFS_FLAGS = 11'h086;
   localparam logic [10:0] REG_ADDR_MASK = 11'h7ff;
   localparam logic [7:0]  SAMPLE_BIAS = 8'h80;

   // datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_NONE   = 5'd0,
      OP_RDREG  = 5'd1,   // read register at address, slot registered for the capture
      OP_WRREG  = 5'd2,
      OP_LOAD   = 5'd3,
      OP_CAPRD  = 5'd4,   // capture register read data into result and right volume
      OP_CAP    = 5'd5,   // capture register data into channel slot
      OP_EVAL   = 5'd6,   // end page check, issue store read
      OP_MIX1   = 5'd7,   // sample minus bias, step product
      OP_MIX2   = 5'd8,   // sample times left and right volume, address step
      OP_ACC    = 5'd9,
      OP_WBFL   = 5'd10,
      OP_WBAL   = 5'd11,
      OP_WBAH   = 5'd12,
      OP_CLRACC = 5'd13
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [10:0] addr;
      logic [2:0]  slot;
      logic [3:0]  chan;
   } cmd_bus_type;

   typedef struct packed {
      logic stopped;        // register file sweep still running
      logic chan_stopped;   // stopped bit of the captured channel flags
   } stat_bus_type;
endpackage
`default_nettype wire

### sv/psp_datapath.sv
// register file, sample store, channel registers and mixing arithmetic
`default_nettype none
module psp_datapath #(
   parameter int CHANNELS  = 16,
   parameter int REG_BYTES = 2048,
   parameter int ROM_BYTES = 131072
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire psp_pkg::cmd_bus_type ctl,
   output      psp_pkg::stat_bus_type stat,
   input  wire logic [7:0]           wr_data,
   input  wire logic [16:0]          rom_addr,
   input  wire logic [7:0]           rom_data,
   input  wire logic [15:0]          step_unit,
   input  wire logic [17:0]          rom_length,
   input  wire logic [4:0]           bank_shift,
   input  wire logic [7:0]           bank_mask,
   output      logic [7:0]           read_data,
   output      logic [19:0]          left_sum,
   output      logic [19:0]          right_sum
);
   import psp_pkg::*;
   localparam int RA_W = $clog2(REG_BYTES);
   localparam int RM_W = $clog2(ROM_BYTES);
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [7:0]  regs_mem [REG_BYTES];
   logic [7:0]  rom_mem  [ROM_BYTES];
   logic [7:0]  rd_ff;
   logic [7:0]  rom_q_ff;
   logic        rom_ok_ff;
   logic [15:0] frac_mem [CHANNELS];
   logic [CHANNELS-1:0] frac_vld_ff;
   logic [15:0] frac_q_ff;
   logic        init_ff;
   logic [RA_W-1:0] init_cnt_ff;

   // channel byte slots: 0 flags 1 adrl 2 adrh 3 endp 4 delta 5 loopl 6 looph 7 lvol
   logic [7:0]  flags_ff, adrl_ff, adrh_ff, endp_ff, delta_ff, loopl_ff, looph_ff;
   logic [7:0]  lvol_ff, rvol_ff;
   logic [31:0] addr_ff;
   logic        stop_ff;
   logic signed [8:0]  samp_ff;
   logic signed [17:0] prodl_ff, prodr_ff;
   logic [23:0] step_ff;
   logic signed [19:0] suml_ff, sumr_ff;
   logic [7:0]  rdres_ff;
   logic [RA_W-1:0] ra;
   logic [2:0]  slot_q_ff;
   logic [39:0] bank_w;
   logic [40:0] off_w;
   logic [31:0] a_w;
   logic [CH_W-1:0] ch;

   assign ra = ctl.addr[RA_W-1:0];
   assign ch = ctl.chan[CH_W-1:0];

   // register file with a sweep that fills it with 0xff after reset
   always_ff @(posedge clock) begin
      if (init_ff)
         regs_mem[init_cnt_ff] <= 8'hff;
      else if (ctl.op == OP_WRREG)
         regs_mem[ra] <= wr_data;
      else if (ctl.op == OP_WBFL)
         regs_mem[ra] <= flags_ff;
      else if (ctl.op == OP_WBAL)
         regs_mem[ra] <= addr_ff[23:16];
      else if (ctl.op == OP_WBAH)
         regs_mem[ra] <= addr_ff[31:24];
      rd_ff <= regs_mem[ra];
      slot_q_ff <= ctl.slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff     <= 1'b1;
         init_cnt_ff <= '0;
      end else if (init_ff) begin
         init_cnt_ff <= init_cnt_ff + 1'b1;
         if (init_cnt_ff == RA_W'(REG_BYTES - 1)) init_ff <= 1'b0;
      end
   end

   // sample store
   always_ff @(posedge clock) begin
      if (ctl.op == OP_LOAD && 32'(rom_addr) < 32'(ROM_BYTES))
         rom_mem[rom_addr[RM_W-1:0]] <= rom_data;
      rom_q_ff <= rom_mem[off_w[RM_W-1:0]];
   end

   // address fraction store, valid bits for reset value
   always_ff @(posedge clock) begin
      if (ctl.op == OP_WBFL)
         frac_mem[ch] <= stop_ff ? 16'h0 : addr_ff[15:0];
      frac_q_ff <= frac_mem[ch];
   end
   always_ff @(posedge clock) begin
      if (reset) frac_vld_ff <= '0;
      else if (ctl.op == OP_WBFL) frac_vld_ff[ch] <= 1'b1;
   end

   // capture of channel bytes, delayed by the register read latency
   always_ff @(posedge clock) begin
      if (ctl.op == OP_CAP) begin
         case (slot_q_ff)
            3'd0: flags_ff <= rd_ff;
            3'd1: adrl_ff  <= rd_ff;
            3'd2: adrh_ff  <= rd_ff;
            3'd3: endp_ff  <= rd_ff;
            3'd4: delta_ff <= rd_ff;
            3'd5: loopl_ff <= rd_ff;
            3'd6: looph_ff <= rd_ff;
            3'd7: lvol_ff  <= rd_ff;
            default: ;
         endcase
      end else if (ctl.op == OP_EVAL) begin
         // a no-loop channel at its end page stops
         flags_ff <= flags_ff | {7'd0, (adrh_ff == endp_ff + 8'd1) && flags_ff[1]};
      end
      if (ctl.op == OP_CAPRD) begin
         rdres_ff <= rd_ff;
         rvol_ff  <= rd_ff;
      end
   end

   // end page check and bank offset
   always_comb begin
      a_w = {adrh_ff, adrl_ff, frac_vld_ff[ch] ? frac_q_ff : 16'h0};
      if (adrh_ff == endp_ff + 8'd1 && !flags_ff[1])
         a_w = {looph_ff, loopl_ff, 16'h0};
      bank_w = 40'(flags_ff & bank_mask) << bank_shift;
      off_w  = 41'(bank_w) + 41'(a_w[31:16]);
   end

   always_ff @(posedge clock) begin
      if (ctl.op == OP_EVAL) begin
         addr_ff   <= a_w;
         stop_ff   <= (adrh_ff == endp_ff + 8'd1) && flags_ff[1];
         rom_ok_ff <= off_w < 41'(rom_length) && off_w < 41'(ROM_BYTES);
      end
      if (ctl.op == OP_MIX1) begin
         samp_ff  <= rom_ok_ff ? ($signed({1'b0, rom_q_ff}) - $signed({1'b0, SAMPLE_BIAS}))
                               : 9'sd0;
         step_ff  <= delta_ff * step_unit;
      end
      if (ctl.op == OP_MIX2) begin
         prodl_ff <= samp_ff * $signed({1'b0, lvol_ff});
         prodr_ff <= samp_ff * $signed({1'b0, rvol_ff});
         if (!stop_ff) addr_ff <= addr_ff + 32'(step_ff);
      end
   end

   // mix accumulators
   always_ff @(posedge clock) begin
      if (reset || ctl.op == OP_CLRACC) begin
         suml_ff <= '0;
         sumr_ff <= '0;
      end else if (ctl.op == OP_ACC && !stop_ff) begin
         suml_ff <= suml_ff + 20'(prodl_ff);
         sumr_ff <= sumr_ff + 20'(prodr_ff);
      end
   end

   assign stat = '{stopped: init_ff, chan_stopped: flags_ff[0]};
   assign read_data = rdres_ff;
   assign left_sum  = suml_ff;
   assign right_sum = sumr_ff;
endmodule
`default_nettype wire

### sv/psp_control.sv
// sequencer that steps commands and channels through the datapath
`default_nettype none
module psp_control #(
   parameter int CHANNELS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [1:0]            req_cmd,
   input  wire logic [10:0]           req_reg_addr,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic                  rsp_is_read,
   output      logic                  rsp_is_tick,
   output      psp_pkg::cmd_bus_type  ctl,
   input  wire psp_pkg::stat_bus_type stat
);
   import psp_pkg::*;
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FLAGS = 6'b000010,
      ST_FETCH = 6'b000100,
      ST_CALC  = 6'b001000,
      ST_BACK  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  chan_ff, chan_in;
   logic [3:0]  step_ff, step_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic        rv_ff, rv_in;
   logic [10:0] base;
   logic        take;

   assign base = {3'd0, chan_ff[3:0], 3'd0};
   assign take = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !stat.stopped && !rv_ff;

   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      step_in  = step_ff;
      cmd_in   = cmd_ff;
      rv_in    = rv_ff && !rsp_ready;
      ctl      = '{op: OP_NONE, addr: 11'd0, slot: 3'd0, chan: chan_ff[3:0]};
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd_in = req_cmd;
               chan_in = '0;
               step_in = '0;
               if (req_cmd == CMD_TICK) begin
                  ctl.op = OP_CLRACC;
                  state_in = ST_FLAGS;
               end else begin
                  ctl.op = (req_cmd == CMD_WRITE) ? OP_WRREG
                         : (req_cmd == CMD_LOAD) ? OP_LOAD : OP_RDREG;
                  ctl.addr = req_reg_addr & REG_ADDR_MASK;
                  state_in = (req_cmd == CMD_READ) ? ST_DONE : ST_IDLE;
                  rv_in = (req_cmd != CMD_READ);
               end
            end
         end
         ST_FLAGS: begin
            // read flags, then capture them from the registered read
            if (step_ff == 4'd0) begin
               ctl.op = OP_RDREG; ctl.addr = base + OFS_FLAGS; ctl.slot = 3'd0;
               step_in = 4'd1;
            end else begin
               ctl.op = OP_CAP;
               step_in = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd0 && stat.chan_stopped) begin
               // skip a stopped channel once the flags are in
               step_in = '0;
               chan_in = chan_ff + 5'd1;
               state_in = (chan_ff == 5'(CHANNELS - 1)) ? ST_DONE : ST_FLAGS;
            end else begin
               case (step_ff)
                  4'd0: begin ctl.op = OP_RDREG; ctl.addr = base + OFS_ADRL; ctl.slot = 3'd1; end
                  4'd1: begin ctl.op = OP_CAP; ctl.addr = base + OFS_ADRH; ctl.slot = 3'd2; end
                  4'd2: begin ctl.op = OP_CAP; ctl.addr = base + OFS_ENDP; ctl.slot = 3'd3; end
                  4'd3: begin ctl.op = OP_CAP; ctl.addr = base + OFS_DELTA; ctl.slot = 3'd4; end
                  4'd4: begin ctl.op = OP_CAP; ctl.addr = base + OFS_LOOPL; ctl.slot = 3'd5; end
                  4'd5: begin ctl.op = OP_CAP; ctl.addr = base + OFS_LOOPH; ctl.slot = 3'd6; end
                  4'd6: begin ctl.op = OP_CAP; ctl.addr = base + OFS_LVOL; ctl.slot = 3'd7; end
                  4'd7: begin ctl.op = OP_CAP; ctl.addr = base + OFS_RVOL; ctl.slot = 3'd7; end
                  default: begin
                     ctl.op = OP_CAPRD; ctl.addr = base + OFS_ADRL;
                     step_in = '0;
                     state_in = ST_CALC;
                  end
               endcase
            end
         end
         ST_CALC: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0: ctl.op = OP_EVAL;
               4'd1: ctl.op = OP_MIX1;
               4'd2: ctl.op = OP_MIX2;
               default: begin
                  ctl.op = OP_ACC;
                  step_in = '0;
                  state_in = ST_BACK;
               end
            endcase
         end
         ST_BACK: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0: begin ctl.op = OP_WBFL; ctl.addr = base + OFS_FLAGS; end
               4'd1: begin ctl.op = OP_WBAL; ctl.addr = base + OFS_ADRL; end
               default: begin
                  ctl.op = OP_WBAH; ctl.addr = base + OFS_ADRH;
                  step_in = '0;
                  chan_in = chan_ff + 5'd1;
                  state_in = (chan_ff == 5'(CHANNELS - 1)) ? ST_DONE : ST_FLAGS;
               end
            endcase
         end
         ST_DONE: begin
            if (cmd_ff == CMD_READ && !rv_ff) ctl.op = OP_CAPRD;
            if (!rv_ff) begin
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         chan_ff  <= '0;
         step_ff  <= '0;
         cmd_ff   <= CMD_TICK;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         chan_ff  <= chan_in;
         step_ff  <= step_in;
         cmd_ff   <= cmd_in;
      end
   end

   assign rsp_valid   = rv_ff;
   assign rsp_is_read = (cmd_ff == CMD_READ);
   assign rsp_is_tick = (cmd_ff == CMD_TICK);
endmodule
`default_nettype wire

### sv/pcm_sample_player_16ch_unit.sv
// top level of the sixteen channel pcm sample player
// sequence: write and load respond straight from idle, a read passes through done; a tick steps
// each active channel through flags, fetch, calc and back, and skips a stopped one after its flags
// throughput: one transfer at a time; next request taken the cycle after the response
// reset: synchronous; register file swept to 0xff after reset
// during that sweep no request is taken; csr writes still apply
`default_nettype none
module pcm_sample_player_16ch_unit #(
   parameter int CHANNELS  = 16,
   parameter int REG_BYTES = 2048,
   parameter int ROM_BYTES = 131072
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [10:0] req_reg_addr,
   input  wire logic [7:0]  req_reg_data,
   input  wire logic [16:0] req_rom_addr,
   input  wire logic [7:0]  req_rom_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [7:0]  rsp_read_data,
   output      logic signed [19:0] rsp_left_sample,
   output      logic signed [19:0] rsp_right_sample,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [17:0] csr_data
);
   import psp_pkg::*;
   cmd_bus_type  ctl;
   stat_bus_type stat;
   logic [15:0] step_unit_ff;
   logic [17:0] rom_length_ff;
   logic [4:0]  bank_shift_ff;
   logic [7:0]  bank_mask_ff;
   logic        is_read, is_tick;
   logic [7:0]  rdat;
   logic [19:0] lsum, rsum;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_unit_ff  <= 16'd512;
         rom_length_ff <= 18'd131072;
         bank_shift_ff <= 5'd16;
         bank_mask_ff  <= 8'd112;
      end else if (csr_write) begin
         case (csr_index)
            CSR_STEP_UNIT:  step_unit_ff  <= csr_data[15:0];
            CSR_ROM_LENGTH: rom_length_ff <= csr_data;
            CSR_BANK_SHIFT: bank_shift_ff <= csr_data[4:0];
            CSR_BANK_MASK:  bank_mask_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   psp_control #(.CHANNELS(CHANNELS)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_cmd, .req_reg_addr,
      .rsp_valid, .rsp_ready, .rsp_is_read(is_read), .rsp_is_tick(is_tick),
      .ctl, .stat
   );

   psp_datapath #(.CHANNELS(CHANNELS), .REG_BYTES(REG_BYTES), .ROM_BYTES(ROM_BYTES)) u_dp (
      .clock, .reset, .ctl, .stat, .wr_data(req_reg_data),
      .rom_addr(req_rom_addr), .rom_data(req_rom_data),
      .step_unit(step_unit_ff), .rom_length(rom_length_ff),
      .bank_shift(bank_shift_ff), .bank_mask(bank_mask_ff),
      .read_data(rdat), .left_sum(lsum), .right_sum(rsum)
   );

   // result fields per command kind
   assign rsp_read_data    = is_read ? rdat : 8'd0;
   assign rsp_left_sample  = is_tick ? lsum : 20'sd0;
   assign rsp_right_sample = is_tick ? rsum : 20'sd0;

   // no request is taken while a response waits
   assert property (@(posedge clock) disable iff (reset) rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken under pending response");
   // a rising response is checked against the past handshake; the past rsp_valid term makes it always hold
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready) || $past(req_valid) || $past(rsp_valid) == 1'b0)
      else $error("spurious response");
   // reset clears the response
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule
`default_nettype wire

### bench/pcm_sample_player_16ch_unit_test.sv
// self-checking bench for the sixteen channel pcm sample player
module pcm_sample_player_16ch_unit_test;
   import psp_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_TICK;
   logic [10:0] req_reg_addr = '0;
   logic [7:0]  req_reg_data = '0;
   logic [16:0] req_rom_addr = '0;
   logic [7:0]  req_rom_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic signed [19:0] rsp_left_sample;
   logic signed [19:0] rsp_right_sample;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_STEP_UNIT;
   logic [17:0] csr_data = '0;

   pcm_sample_player_16ch_unit DUT (.*);

   always #6 clock = ~clock;

   // expected response of one transfer
   typedef struct {
      logic [7:0]         read_data;
      logic signed [19:0] left;
      logic signed [19:0] right;
   } mix_result_type;

   mix_result_type pending_mix[$];
   int        fail_count = 0;

   // shadow copy of the player state
   logic [7:0]  shadow_regs[2048];
   logic [15:0] shadow_frac[16];
   logic [7:0]  shadow_store[131072];
   logic [15:0] cfg_step_unit = 16'd512;
   logic [17:0] cfg_rom_length = 18'd131072;
   logic [4:0]  cfg_bank_shift = 5'd16;
   logic [7:0]  cfg_bank_mask = 8'd112;

   // receiver control
   bit rsp_steady = 1'b0;
   bit hold_go = 1'b0;
   bit send_steady = 1'b0;

   // one mixing pass over all channels
   function automatic mix_result_type mix_tick();
      mix_result_type res;
      int        sum_l, sum_r, v, c;
      logic [10:0] base;
      logic [7:0]  flags, endp;
      logic [31:0] addr, step;
      logic [15:0] loop_addr;
      logic [63:0] bank, offset;
      bit          halted;
      sum_l = 0;
      sum_r = 0;
      for (c = 0; c < 16; c++) begin
         base = 11'(8 * c);
         flags = shadow_regs[base + OFS_FLAGS];
         if (flags[0]) continue;
         addr = {shadow_regs[base + OFS_ADRH], shadow_regs[base + OFS_ADRL], shadow_frac[c]};
         loop_addr = {shadow_regs[base + OFS_LOOPH], shadow_regs[base + OFS_LOOPL]};
         endp = shadow_regs[base + OFS_ENDP] + 8'd1;
         step = 32'(shadow_regs[base + OFS_DELTA]) * 32'(cfg_step_unit);
         bank = 64'(flags & cfg_bank_mask) << cfg_bank_shift;
         halted = 1'b0;
         // end page: loop back or stop
         if (addr[31:24] == endp) begin
            if (!flags[1]) begin
               addr = {loop_addr, 16'h0000};
            end else begin
               flags[0] = 1'b1;
               halted = 1'b1;
            end
         end
         if (!halted) begin
            offset = bank + 64'(addr[31:16]);
            if (offset < 64'(cfg_rom_length) && offset < 64'd131072)
               v = int'(shadow_store[offset[16:0]]) - 128;
            else
               v = 0;
            sum_l += v * int'(shadow_regs[base + OFS_LVOL]);
            sum_r += v * int'(shadow_regs[base + OFS_RVOL]);
            addr = addr + step;
         end
         shadow_regs[base + OFS_FLAGS] = flags;
         shadow_regs[base + OFS_ADRL] = addr[23:16];
         shadow_regs[base + OFS_ADRH] = addr[31:24];
         shadow_frac[c] = halted ? 16'h0000 : addr[15:0];
      end
      res.read_data = '0;
      res.left = sum_l[19:0];
      res.right = sum_r[19:0];
      return res;
   endfunction

   // expected response of one accepted request
   function automatic mix_result_type apply_request(logic [1:0] cmd, logic [10:0] ra,
                                                    logic [7:0] rd, logic [16:0] ma,
                                                    logic [7:0] md);
      mix_result_type res;
      res.read_data = '0;
      res.left = '0;
      res.right = '0;
      case (cmd)
         CMD_TICK: res = mix_tick();
         CMD_WRITE: shadow_regs[ra & REG_ADDR_MASK] = rd;
         CMD_READ: res.read_data = shadow_regs[ra & REG_ADDR_MASK];
         default: shadow_store[ma] = md;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, int expected, int got);
      $display("mismatch %s: expected %0d got %0d at %0t", what, expected, got, $realtime);
      fail_count++;
   endtask

   // check each response transfer against the oldest expectation
   always @(posedge clock) begin
      mix_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_mix.size() == 0) begin
            report_mismatch("unexpected response", 0, 1);
         end else begin
            want = pending_mix.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", want.read_data, rsp_read_data);
            if (rsp_left_sample !== want.left)
               report_mismatch("left_sample", want.left, rsp_left_sample);
            if (rsp_right_sample !== want.right)
               report_mismatch("right_sample", want.right, rsp_right_sample);
         end
      end
   end

   // receiver stalls: random short and long, plus a counted long hold
   initial begin
      int stall_left, hold_left, r;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_steady) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 12) stall_left = $urandom_range(0, 2);
            else if (r < 14) stall_left = $urandom_range(15, 50);
            rsp_ready <= (r >= 14) || (r < 12 && stall_left == 0) ? 1'b1 : 1'b0;
         end
      end
   end

   // one request transfer; valid stays high until accepted
   task automatic send_request(logic [1:0] cmd, logic [10:0] ra, logic [7:0] rd,
                               logic [16:0] ma, logic [7:0] md);
      @(negedge clock);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_reg_addr <= ra;
      req_reg_data <= rd;
      req_rom_addr <= ma;
      req_rom_data <= md;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      pending_mix.push_back(apply_request(cmd, ra, rd, ma, md));
   endtask

   // sender gap after a transfer
   task automatic sender_gap();
      int r, n;
      r = $urandom_range(0, 99);
      n = 0;
      if (!send_steady) begin
         if (r < 25) n = $urandom_range(1, 3);
         else if (r < 29) n = $urandom_range(10, 40);
      end
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // wait for all responses and then for the tick latency
   task automatic drain_responses();
      stop_sending();
      while (pending_mix.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [17:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_STEP_UNIT: cfg_step_unit = value[15:0];
         CSR_ROM_LENGTH: cfg_rom_length = value;
         CSR_BANK_SHIFT: cfg_bank_shift = value[4:0];
         default: cfg_bank_mask = value[7:0];
      endcase
   endtask

   task automatic write_reg(int chan, logic [10:0] ofs, logic [7:0] value);
      send_request(CMD_WRITE, 11'(8 * chan) + ofs, value, '0, '0);
      sender_gap();
   endtask

   // one random request, mostly channel set-up and ticks
   task automatic random_request();
      int r, chan;
      logic [10:0] ofs, ra;
      logic [7:0]  data;
      r = $urandom_range(0, 99);
      chan = $urandom_range(0, 15);
      data = 8'($urandom);
      if (r < 40) begin
         case ($urandom_range(0, 9))
            0: ofs = OFS_LVOL;
            1: ofs = OFS_RVOL;
            2: ofs = OFS_ADRL;
            3: ofs = OFS_ADRH;
            4: ofs = OFS_ENDP;
            5: ofs = OFS_DELTA;
            6: ofs = OFS_LOOPL;
            7: ofs = OFS_LOOPH;
            default: begin
               ofs = OFS_FLAGS;
               if ($urandom_range(0, 3) != 0) data[0] = 1'b0;
            end
         endcase
         ra = 11'(8 * chan) + ofs;
         if ($urandom_range(0, 4) == 0) ra = 11'($urandom);
         send_request(CMD_WRITE, ra, data, 17'($urandom), 8'($urandom));
      end else if (r < 70) begin
         send_request(CMD_TICK, 11'($urandom), data, 17'($urandom), 8'($urandom));
      end else if (r < 90) begin
         send_request(CMD_READ, 11'($urandom), data, 17'($urandom), 8'($urandom));
      end else begin
         send_request(CMD_LOAD, 11'($urandom), data, 17'($urandom), 8'($urandom));
      end
      sender_gap();
   endtask

   task automatic test_register_access();
      send_request(CMD_READ, 11'h000, 8'h00, '0, '0);
      send_request(CMD_READ, 11'h7ff, 8'h00, '0, '0);
      send_request(CMD_WRITE, 11'h000, 8'h00, '0, '0);
      send_request(CMD_WRITE, 11'h7ff, 8'hff, '0, '0);
      send_request(CMD_WRITE, 11'h555, 8'h5a, '0, '0);
      send_request(CMD_READ, 11'h000, 8'hff, '0, '0);
      send_request(CMD_READ, 11'h7ff, 8'h00, '0, '0);
      send_request(CMD_READ, 11'h555, 8'h00, '0, '0);
      drain_responses();
   endtask

   // load the low store bytes; rom_length keeps every mixing read inside them
   task automatic test_store_fill();
      int a;
      rsp_steady = 1'b1;
      for (a = 0; a < 256; a++)
         send_request(CMD_LOAD, 11'($urandom), 8'($urandom), 17'(a), 8'($urandom));
      rsp_steady = 1'b0;
      drain_responses();
      write_csr(CSR_ROM_LENGTH, 18'd256);
   endtask

   task automatic test_channel_cases();
      int c;
      // set up volumes, delta and high address of the first four channels
      for (c = 0; c < 4; c++) begin
         write_reg(c, OFS_LVOL, 8'hff);
         write_reg(c, OFS_RVOL, 8'h00);
         write_reg(c, OFS_DELTA, 8'hff);
         write_reg(c, OFS_ADRH, 8'h00);
      end
      // looping channel reaches its end page
      write_reg(0, OFS_ENDP, 8'h00);
      write_reg(0, OFS_ADRH, 8'h01);
      write_reg(0, OFS_LOOPL, 8'h34);
      write_reg(0, OFS_LOOPH, 8'h00);
      write_reg(0, OFS_FLAGS, 8'h00);
      // no-loop channel stops at its end page
      write_reg(1, OFS_ENDP, 8'h00);
      write_reg(1, OFS_ADRH, 8'h01);
      write_reg(1, OFS_FLAGS, 8'h02);
      // address wraps past the top
      write_reg(2, OFS_ADRH, 8'hff);
      write_reg(2, OFS_ENDP, 8'h10);
      write_reg(2, OFS_FLAGS, 8'h70);
      repeat (4) begin
         send_request(CMD_TICK, '0, '0, '0, '0);
         sender_gap();
      end
      send_request(CMD_READ, 11'(8 + OFS_FLAGS), '0, '0, '0);
      drain_responses();
   endtask

   // random traffic under one csr setting
   task automatic run_phase(logic [15:0] step, logic [17:0] len, logic [4:0] shift,
                            logic [7:0] mask, int count);
      write_csr(CSR_STEP_UNIT, 18'(step));
      write_csr(CSR_ROM_LENGTH, len);
      write_csr(CSR_BANK_SHIFT, 18'(shift));
      write_csr(CSR_BANK_MASK, 18'(mask));
      repeat (count) random_request();
      drain_responses();
   endtask

   task automatic test_config_sweep();
      run_phase(16'd512, 18'd256, 5'd16, 8'd112, 300);
      run_phase(16'hffff, 18'd0, 5'd0, 8'hff, 200);
      run_phase(16'd0, 18'd256, 5'd24, 8'h00, 150);
      run_phase(16'd4096, 18'd200, 5'd12, 8'hf0, 300);
      send_steady = 1'b1;
      run_phase(16'd37, 18'd256, 5'd1, 8'hfe, 200);
      send_steady = 1'b0;
      run_phase(16'($urandom), 18'($urandom_range(0, 256)), 5'($urandom_range(0, 24)),
                8'($urandom), 150);
   endtask

   // long receiver hold while requests keep coming
   task automatic test_backpressure();
      hold_go = 1'b1;
      repeat (40) random_request();
      drain_responses();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (shadow_regs[i]) shadow_regs[i] = 8'hff;
      foreach (shadow_frac[i]) shadow_frac[i] = 16'h0000;
      write_csr(CSR_STEP_UNIT, 18'd512);
      test_register_access();
      test_store_fill();
      test_channel_cases();
      test_config_sweep();
      test_backpressure();
      drain_responses();
      if (fail_count == 0)
         $display("pcm_sample_player_16ch_unit_test OK");
      else
         $display("pcm_sample_player_16ch_unit_test NOT OK");
      $finish;
   end

   // overall time limit
   initial begin
      #150000000;
      $display("pcm_sample_player_16ch_unit_test NOT OK");
      $finish;
   end
endmodule

### pcm_sample_player_16ch_unit.f
sv/psp_pkg.sv
sv/psp_datapath.sv
sv/psp_control.sv
sv/pcm_sample_player_16ch_unit.sv
bench/pcm_sample_player_16ch_unit_test.sv
